[rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// stc_pkg: shared types, constants and functions for the token classifier
// Grammar state codes, result class codes, character constants and the
// per-character number-grammar transition function.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 3;
    localparam int MAG_W   = 53;
    localparam int ACC_W   = MAG_W + 1;   // holds the saturation value 2^53
    localparam int KPOS_W  = 3;

    // 2^53, the saturation value of the accumulator
    localparam logic [ACC_W-1:0] ACC_SAT = {1'b1, {MAG_W{1'b0}}};

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;   // '-'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;   // '+'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;   // '.'
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;   // '9'
    localparam logic [CHAR_W-1:0] CH_E_LO  = 8'h65;   // 'e'
    localparam logic [CHAR_W-1:0] CH_E_UP  = 8'h45;   // 'E'

    typedef enum logic [3:0] {
        G_START   = 4'd0,
        G_MINUS   = 4'd1,
        G_ZERO    = 4'd2,
        G_INT     = 4'd3,
        G_DOT     = 4'd4,
        G_FRAC    = 4'd5,
        G_EXP     = 4'd6,
        G_EXPSIGN = 4'd7,
        G_EXPDIG  = 4'd8,
        G_DEAD    = 4'd9
    } t_gstate;

    typedef enum logic [CLASS_W-1:0] {
        CLS_STRING  = 3'd0,
        CLS_TRUE    = 3'd1,
        CLS_FALSE   = 3'd2,
        CLS_INTEGER = 3'd3,
        CLS_DECIMAL = 3'd4
    } t_class;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_item;

    typedef struct packed {
        t_class           token_class;
        logic             is_negative;
        logic [MAG_W-1:0] magnitude;
    } t_result;

    function automatic logic is_digit(logic [CHAR_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic t_gstate next_grammar(t_gstate g, logic [CHAR_W-1:0] c);
        logic    d;
        logic    e;
        t_gstate ng;
        d  = is_digit(c);
        e  = (c == CH_E_LO) || (c == CH_E_UP);
        ng = G_DEAD;
        case (g)
            G_START: begin
                if (c == CH_MINUS)  ng = G_MINUS;
                else if (c == CH_0) ng = G_ZERO;
                else if (d)         ng = G_INT;
            end
            G_MINUS: begin
                if (c == CH_0) ng = G_ZERO;
                else if (d)    ng = G_INT;
            end
            G_ZERO: begin
                if (c == CH_DOT) ng = G_DOT;
                else if (e)      ng = G_EXP;
            end
            G_INT: begin
                if (d)                ng = G_INT;
                else if (c == CH_DOT) ng = G_DOT;
                else if (e)           ng = G_EXP;
            end
            G_DOT: begin
                if (d) ng = G_FRAC;
            end
            G_FRAC: begin
                if (d)      ng = G_FRAC;
                else if (e) ng = G_EXP;
            end
            G_EXP: begin
                if (c == CH_PLUS || c == CH_MINUS) ng = G_EXPSIGN;
                else if (d)                        ng = G_EXPDIG;
            end
            G_EXPSIGN, G_EXPDIG: begin
                if (d) ng = G_EXPDIG;
            end
            default: begin
                ng = G_DEAD;
            end
        endcase
        return ng;
    endfunction

    // Keyword letters by position
    function automatic logic [CHAR_W-1:0] true_char(logic [1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            2'd0:    ch = 8'h74;   // 't'
            2'd1:    ch = 8'h72;   // 'r'
            2'd2:    ch = 8'h75;   // 'u'
            default: ch = 8'h65;   // 'e'
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] false_char(logic [KPOS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h66;   // 'f'
            3'd1:    ch = 8'h61;   // 'a'
            3'd2:    ch = 8'h6C;   // 'l'
            3'd3:    ch = 8'h73;   // 's'
            3'd4:    ch = 8'h65;   // 'e'
            default: ch = 8'h66;   // past the word, never matched
        endcase
        return ch;
    endfunction

endpackage

[rtl/stc_in_stage.sv]
// ----------------------------------------------------------------------------
// stc_in_stage: input register
// Captures one character transaction and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module stc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  stc_pkg::t_item i_item,
    output logic          o_ready,
    output logic          o_valid,
    output stc_pkg::t_item o_item,
    input  logic          i_take
);
    import stc_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/stc_engine.sv]
// ----------------------------------------------------------------------------
// stc_engine: per-character classifier state and update logic
// Number-grammar DFA, saturating x10 accumulator and keyword matchers.
// ----------------------------------------------------------------------------
module stc_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  stc_pkg::t_item  i_item,
    input  logic            i_out_free,
    output logic            o_take,
    output logic            o_load,
    output stc_pkg::t_result o_result
);
    import stc_pkg::*;

    localparam int PROD_W = ACC_W + 4;

    t_gstate            r_gstate,  n_gstate;
    logic [ACC_W-1:0]   r_acc,     n_acc;
    logic               r_minus,   n_minus;
    logic [KPOS_W-1:0]  r_kpos,    n_kpos;
    logic               r_true_ok, n_true_ok;
    logic               r_false_ok, n_false_ok;

    logic [PROD_W-1:0]  acc_wide;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  digit;
    logic [CHAR_W-1:0]  c;
    t_class             cls;

    assign c = i_item.char_code;

    // a last character needs a free output slot; others always proceed
    assign o_take = i_valid && (!i_item.last || i_out_free);
    assign o_load = o_take && i_item.last;

    always_comb begin
        n_gstate = next_grammar(r_gstate, c);
        n_minus  = r_minus || ((r_gstate == G_START) && (c == CH_MINUS));

        // a*10 + digit, clamped to 2^53
        acc_wide = {4'b0, r_acc};
        digit    = {{(PROD_W-CHAR_W){1'b0}}, c - CH_0};
        prod     = (acc_wide << 3) + (acc_wide << 1) + digit;
        n_acc    = r_acc;
        if (n_gstate == G_INT && !r_acc[ACC_W-1]) begin
            if (prod > {4'b0, ACC_SAT}) n_acc = ACC_SAT;
            else                        n_acc = prod[ACC_W-1:0];
        end

        n_true_ok  = r_true_ok  && !r_kpos[2] && (true_char(r_kpos[1:0]) == c);
        n_false_ok = r_false_ok && (r_kpos < 3'd5) && (false_char(r_kpos) == c);
        n_kpos     = (r_kpos == 3'd7) ? r_kpos : r_kpos + 3'd1;
    end

    always_comb begin
        if (n_true_ok && n_kpos == 3'd4) begin
            cls = CLS_TRUE;
        end else if (n_false_ok && n_kpos == 3'd5) begin
            cls = CLS_FALSE;
        end else if (n_gstate == G_ZERO || n_gstate == G_INT) begin
            // saturated value means above the safe range
            cls = n_acc[ACC_W-1] ? CLS_STRING : CLS_INTEGER;
        end else if (n_gstate == G_FRAC || n_gstate == G_EXPDIG) begin
            cls = CLS_DECIMAL;
        end else begin
            cls = CLS_STRING;
        end
        o_result.token_class = cls;
        o_result.is_negative = n_minus;
        o_result.magnitude   = (cls == CLS_INTEGER) ? n_acc[MAG_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gstate   <= G_START;
            r_acc      <= '0;
            r_minus    <= 1'b0;
            r_kpos     <= '0;
            r_true_ok  <= 1'b1;
            r_false_ok <= 1'b1;
        end else if (o_take) begin
            if (i_item.last) begin
                r_gstate   <= G_START;
                r_acc      <= '0;
                r_minus    <= 1'b0;
                r_kpos     <= '0;
                r_true_ok  <= 1'b1;
                r_false_ok <= 1'b1;
            end else begin
                r_gstate   <= n_gstate;
                r_acc      <= n_acc;
                r_minus    <= n_minus;
                r_kpos     <= n_kpos;
                r_true_ok  <= n_true_ok;
                r_false_ok <= n_false_ok;
            end
        end
    end

endmodule

[rtl/stc_out_stage.sv]
// ----------------------------------------------------------------------------
// stc_out_stage: result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module stc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stc_pkg::t_result i_result,
    output logic             o_free,
    output logic             o_valid,
    output stc_pkg::t_result o_result,
    input  logic             i_ready
);
    import stc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/scalar_token_classifier_core.sv]
// ----------------------------------------------------------------------------
// scalar_token_classifier_core: scalar text token classifier
// Classifies a token as true, false, safe integer, decimal or string.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready): one character per transaction,
//   i_char_code with i_last marking the final character of the token.
//   Output channel (o_out_valid / i_out_ready): one result transaction per
//   token, raised for the character that carried i_last; class, sign flag
//   and integer magnitude (zero unless the class is safe integer).
//   Path: a final character passes the input register, then the engine
//   loads its result into the result register.
//   Throughput: one character per cycle while no final character waits for
//   the result register. The limit is the combinational per-character update
//   (grammar DFA plus saturating x10 add) between input and result registers.
//   Stall: a waiting result does not block non-final characters; a final
//   character waits in the input register until the result register frees,
//   and o_in_ready drops only then.
//   Reset (i_rst_n low, synchronous): both registers empty, the classifier
//   returns to the start of a token. No clearing pass.
// ----------------------------------------------------------------------------
module scalar_token_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_token_class,
    output logic        o_is_negative,
    output logic [52:0] o_magnitude
);
    import stc_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    take;
    logic    load;
    logic    out_free;
    t_result eng_result;
    t_result out_result;

    assign in_item.char_code = i_char_code;
    assign in_item.last      = i_last;

    // input register
    stc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_ready (o_in_ready),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (take)
    );

    // classifier state and update
    stc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (stage_valid),
        .i_item     (stage_item),
        .i_out_free (out_free),
        .o_take     (take),
        .o_load     (load),
        .o_result   (eng_result)
    );

    // result register
    stc_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (eng_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result),
        .i_ready  (i_out_ready)
    );

    assign o_token_class = out_result.token_class;
    assign o_is_negative = out_result.is_negative;
    assign o_magnitude   = out_result.magnitude;

endmodule

[rtl/stc_checker.sv]
// ----------------------------------------------------------------------------
// stc_checker: port-level checks for the token classifier
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
module stc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_token_class,
    input logic        o_is_negative,
    input logic [52:0] o_magnitude
);
    import stc_pkg::*;

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_token_class) && $stable(o_is_negative)
            && $stable(o_magnitude))
        else $error("result changed while stalled");

    // with the result register empty nothing can block the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // magnitude only carries a value for safe integers
    a_mag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_class != CLS_INTEGER) |-> (o_magnitude == '0))
        else $error("non-zero magnitude on non-integer class");

    // keywords never start with a minus
    a_kw_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_token_class == CLS_TRUE || o_token_class == CLS_FALSE)
            |-> !o_is_negative)
        else $error("negative keyword");

    // class code within the defined range
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_token_class <= CLS_DECIMAL))
        else $error("class code out of range");

endmodule

bind scalar_token_classifier_core stc_checker u_stc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_token_class (o_token_class),
    .o_is_negative (o_is_negative),
    .o_magnitude   (o_magnitude)
);
